/* rtl/core/rasd_pkg.sv */
// shared types, constants and pattern tables of the range average display
`default_nettype none

package rasd_pkg;

  // field widths
  localparam int unsigned ECHO_W  = 16;
  localparam int unsigned VALUE_W = 14;
  localparam int unsigned SEG_W   = 7;
  localparam int unsigned EN_W    = 4;
  localparam int unsigned SUM_W   = 20;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned POS_W   = 2;
  localparam int unsigned DIGIT_W = 4;

  // request kinds
  localparam logic CMD_ECHO = 1'b0;
  localparam logic CMD_SCAN = 1'b1;

  // scan positions
  localparam logic [POS_W-1:0] POS_UNITS     = 2'd0;
  localparam logic [POS_W-1:0] POS_TENS      = 2'd1;
  localparam logic [POS_W-1:0] POS_HUNDREDS  = 2'd2;
  localparam logic [POS_W-1:0] POS_THOUSANDS = 2'd3;

  // value constants
  localparam logic [VALUE_W-1:0] LIMIT_RESET  = 14'd1500;
  localparam logic [VALUE_W-1:0] OUT_OF_RANGE = 14'd9999;

  // reciprocal constants for exact division of a 14-bit value by powers of ten
  localparam int unsigned DIV10_S    = 18;
  localparam int unsigned DIV100_S   = 21;
  localparam int unsigned DIV1000_S  = 24;
  localparam int unsigned DIV10000_S = 28;
  localparam logic [31:0] DIV10_M    = 32'(((64'd1 << DIV10_S) + 64'd9) / 64'd10);
  localparam logic [31:0] DIV100_M   = 32'(((64'd1 << DIV100_S) + 64'd99) / 64'd100);
  localparam logic [31:0] DIV1000_M  = 32'(((64'd1 << DIV1000_S) + 64'd999) / 64'd1000);
  localparam logic [31:0] DIV10000_M = 32'(((64'd1 << DIV10000_S) + 64'd9999) / 64'd10000);

  // display status between the averaging and the top level
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               updated;
  } disp_t;

  // segment and digit enable patterns
  typedef struct packed {
    logic [SEG_W-1:0] segments;
    logic [EN_W-1:0]  enables;
  } seg_t;

  // numeral patterns, segment a in bit 0
  function automatic logic [SEG_W-1:0] numeral_pattern(input logic [DIGIT_W-1:0] digit);
    logic [SEG_W-1:0] pat;
    unique case (digit)
      4'd0:    pat = 7'h3F;
      4'd1:    pat = 7'h06;
      4'd2:    pat = 7'h5B;
      4'd3:    pat = 7'h4F;
      4'd4:    pat = 7'h66;
      4'd5:    pat = 7'h6D;
      4'd6:    pat = 7'h7D;
      4'd7:    pat = 7'h07;
      4'd8:    pat = 7'h7F;
      4'd9:    pat = 7'h6F;
      default: pat = 7'h00;
    endcase
    return pat;
  endfunction

  // active-low enables for a numeric value
  function automatic logic [EN_W-1:0] normal_enable(input logic [POS_W-1:0] pos);
    logic [EN_W-1:0] en;
    unique case (pos)
      POS_UNITS:     en = 4'h7;
      POS_TENS:      en = 4'hB;
      POS_HUNDREDS:  en = 4'hD;
      POS_THOUSANDS: en = 4'hE;
      default:       en = 4'hF;
    endcase
    return en;
  endfunction

  // "OUt" spelled right to left, fourth digit blank
  function automatic logic [SEG_W-1:0] oor_pattern(input logic [POS_W-1:0] pos);
    logic [SEG_W-1:0] pat;
    unique case (pos)
      POS_UNITS:     pat = 7'h78;
      POS_TENS:      pat = 7'h3E;
      POS_HUNDREDS:  pat = 7'h3F;
      POS_THOUSANDS: pat = 7'h00;
      default:       pat = 7'h00;
    endcase
    return pat;
  endfunction

  function automatic logic [EN_W-1:0] oor_enable(input logic [POS_W-1:0] pos);
    logic [EN_W-1:0] en;
    unique case (pos)
      POS_UNITS:     en = 4'h7;
      POS_TENS:      en = 4'hB;
      POS_HUNDREDS:  en = 4'hD;
      POS_THOUSANDS: en = 4'hF;
      default:       en = 4'hF;
    endcase
    return en;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/rasd_if.sv */
// request and result channel interfaces
`default_nettype none

interface rasd_in_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [rasd_pkg::ECHO_W-1:0]  echo_count;

  modport source (output valid, output cmd, output echo_count, input ready);
  modport sink   (input valid, input cmd, input echo_count, output ready);
endinterface

interface rasd_out_if;
  logic                         valid;
  logic                         ready;
  logic [rasd_pkg::SEG_W-1:0]   segments;
  logic [rasd_pkg::EN_W-1:0]    digit_enables;
  logic [rasd_pkg::VALUE_W-1:0] shown_value;
  logic                         value_updated;

  modport source (output valid, output segments, output digit_enables,
                  output shown_value, output value_updated, input ready);
  modport sink   (input valid, input segments, input digit_enables,
                  input shown_value, input value_updated, output ready);
endinterface

`default_nettype wire

/* rtl/core/rasd_accum.sv */
// echo sample accumulation, averaging and range check
`default_nettype none

module rasd_accum #(
  parameter int unsigned SAMPLES_PER_AVERAGE = 10
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         take,
  input  wire logic [rasd_pkg::ECHO_W-1:0]  echo_count,
  input  wire logic [rasd_pkg::VALUE_W-1:0] range_limit,
  output rasd_pkg::disp_t                   disp_nxt,
  output logic [rasd_pkg::VALUE_W-1:0]      disp_value
);

  localparam int unsigned SUM_W     = rasd_pkg::SUM_W;
  localparam int unsigned CNT_W     = rasd_pkg::CNT_W;
  localparam int unsigned AVG_SHIFT = SUM_W + 5;
  localparam int unsigned PROD_W    = SUM_W + AVG_SHIFT + 1;
  localparam logic [AVG_SHIFT:0] AVG_M =
    (AVG_SHIFT+1)'(((64'd1 << AVG_SHIFT) + 64'(SAMPLES_PER_AVERAGE) - 64'd1)
                   / 64'(SAMPLES_PER_AVERAGE));
  localparam logic [CNT_W:0] CNT_LAST = (CNT_W+1)'(SAMPLES_PER_AVERAGE);

  logic [SUM_W-1:0]            sum_r, sum_nxt, sum_add;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [CNT_W:0]              cnt_inc;
  logic [rasd_pkg::VALUE_W-1:0] value_r;
  logic [PROD_W-1:0]           avg_prod;
  logic [SUM_W-1:0]            avg;
  logic                        done;

  // running sum and sample count
  assign sum_add = sum_r + SUM_W'(echo_count);
  assign cnt_inc = {1'b0, cnt_r} + (CNT_W+1)'(1);
  assign done    = take && (cnt_inc >= CNT_LAST);

  // divide by the sample count through a reciprocal multiply
  assign avg_prod = PROD_W'(sum_add) * PROD_W'(AVG_M);
  assign avg      = SUM_W'(avg_prod >> AVG_SHIFT);

  // next state and display value
  always_comb begin
    sum_nxt          = sum_r;
    cnt_nxt          = cnt_r;
    disp_nxt.value   = value_r;
    disp_nxt.updated = 1'b0;
    if (done) begin
      sum_nxt          = '0;
      cnt_nxt          = '0;
      disp_nxt.updated = 1'b1;
      if (avg > SUM_W'(range_limit)) begin
        disp_nxt.value = rasd_pkg::OUT_OF_RANGE;
      end else begin
        disp_nxt.value = avg[rasd_pkg::VALUE_W-1:0];
      end
    end else if (take) begin
      sum_nxt = sum_add;
      cnt_nxt = cnt_inc[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      cnt_r   <= '0;
      value_r <= '0;
    end else begin
      sum_r   <= sum_nxt;
      cnt_r   <= cnt_nxt;
      value_r <= disp_nxt.value;
    end
  end

  assign disp_value = value_r;

endmodule

`default_nettype wire

/* rtl/core/rasd_scan.sv */
// digit scan: decimal split, segment decode and pattern latches
`default_nettype none

module rasd_scan (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         take,
  input  wire logic [rasd_pkg::VALUE_W-1:0] disp_value,
  output rasd_pkg::seg_t                    latch_nxt
);

  localparam int unsigned VALUE_W = rasd_pkg::VALUE_W;

  logic [rasd_pkg::POS_W-1:0] pos_r, pos_nxt;
  rasd_pkg::seg_t             latch_r;
  logic [VALUE_W-1:0]         q10, q100, q1000, q10000;
  logic [VALUE_W-1:0]         q_lo, q_hi, digit_diff;
  logic [rasd_pkg::DIGIT_W-1:0] digit;

  // quotients by powers of ten, exact for any 14-bit value
  assign q10    = VALUE_W'((32'(disp_value) * rasd_pkg::DIV10_M) >> rasd_pkg::DIV10_S);
  assign q100   = VALUE_W'((32'(disp_value) * rasd_pkg::DIV100_M) >> rasd_pkg::DIV100_S);
  assign q1000  = VALUE_W'((32'(disp_value) * rasd_pkg::DIV1000_M) >> rasd_pkg::DIV1000_S);
  assign q10000 = VALUE_W'((32'(disp_value) * rasd_pkg::DIV10000_M) >> rasd_pkg::DIV10000_S);

  // pick the digit at the scan position and the next position
  always_comb begin
    unique case (pos_r)
      rasd_pkg::POS_UNITS: begin
        q_lo    = disp_value;
        q_hi    = q10;
        pos_nxt = rasd_pkg::POS_THOUSANDS;
      end
      rasd_pkg::POS_TENS: begin
        q_lo    = q10;
        q_hi    = q100;
        pos_nxt = rasd_pkg::POS_UNITS;
      end
      rasd_pkg::POS_HUNDREDS: begin
        q_lo    = q100;
        q_hi    = q1000;
        pos_nxt = rasd_pkg::POS_TENS;
      end
      default: begin
        q_lo    = q1000;
        q_hi    = q10000;
        pos_nxt = rasd_pkg::POS_HUNDREDS;
      end
    endcase
  end

  // remainder by ten as q_lo - 10 * q_hi
  assign digit_diff = q_lo - ((q_hi << 3) + (q_hi << 1));
  assign digit      = digit_diff[rasd_pkg::DIGIT_W-1:0];

  // pattern decode, latches hold on echo requests
  always_comb begin
    latch_nxt = latch_r;
    if (take) begin
      if (disp_value == rasd_pkg::OUT_OF_RANGE) begin
        latch_nxt.segments = rasd_pkg::oor_pattern(pos_r);
        latch_nxt.enables  = rasd_pkg::oor_enable(pos_r);
      end else begin
        latch_nxt.segments = rasd_pkg::numeral_pattern(digit);
        latch_nxt.enables  = rasd_pkg::normal_enable(pos_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= rasd_pkg::POS_UNITS;
      latch_r <= '0;
    end else begin
      latch_r <= latch_nxt;
      if (take) begin
        pos_r <= pos_nxt;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/range_average_segment_display.sv */
// top level of the range average seven-segment display driver
//
//   channel   direction  payload
//   in_chan   sink       cmd, echo_count
//   out_chan  source     segments, digit_enables, shown_value, value_updated
//   cfg_      write      cfg_wr_en, cfg_wr_data (range_limit)
//
// one request per cycle unless a stalled result blocks it, its result held in the result register
// the single result register sets the rate: a request is taken whenever it
// is empty or being drained
// reset: range_limit 1500, sum, count, value, scan position and latches zero
// a stalled result holds and blocks new requests until it is taken
`default_nettype none

module range_average_segment_display #(
  parameter int unsigned SAMPLES_PER_AVERAGE = 10
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  rasd_in_if.sink                           in_chan,
  rasd_out_if.source                        out_chan,
  input  wire logic                         cfg_wr_en,
  input  wire logic [rasd_pkg::VALUE_W-1:0] cfg_wr_data
);

  logic [rasd_pkg::VALUE_W-1:0] limit_r;
  logic [rasd_pkg::VALUE_W-1:0] disp_value;
  rasd_pkg::disp_t              disp_nxt;
  rasd_pkg::seg_t               latch_nxt;
  logic                         in_ready;
  logic                         accept;
  logic                         take_echo;
  logic                         take_scan;

  logic                         out_valid_r;
  logic [rasd_pkg::SEG_W-1:0]   out_seg_r;
  logic [rasd_pkg::EN_W-1:0]    out_en_r;
  logic [rasd_pkg::VALUE_W-1:0] out_value_r;
  logic                         out_upd_r;

  // range limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= rasd_pkg::LIMIT_RESET;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  // request handshake
  assign in_ready  = rst_n && (!out_valid_r || out_chan.ready);
  assign accept    = in_chan.valid && in_ready;
  assign take_echo = accept && (in_chan.cmd == rasd_pkg::CMD_ECHO);
  assign take_scan = accept && (in_chan.cmd == rasd_pkg::CMD_SCAN);
  assign in_chan.ready = in_ready;

  rasd_accum #(
    .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE)
  ) u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take_echo),
    .echo_count  (in_chan.echo_count),
    .range_limit (limit_r),
    .disp_nxt    (disp_nxt),
    .disp_value  (disp_value)
  );

  rasd_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take_scan),
    .disp_value (disp_value),
    .latch_nxt  (latch_nxt)
  );

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_seg_r   <= latch_nxt.segments;
      out_en_r    <= latch_nxt.enables;
      out_value_r <= disp_nxt.value;
      out_upd_r   <= disp_nxt.updated;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.segments      = out_seg_r;
  assign out_chan.digit_enables = out_en_r;
  assign out_chan.shown_value   = out_value_r;
  assign out_chan.value_updated = out_upd_r;

  // a taken request always leaves a result
  assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_chan.valid)
    else $error("accepted request left no result");

  // a scan tick never completes an average
  assert property (@(posedge clk) disable iff (!rst_n)
    take_scan |=> !out_chan.value_updated)
    else $error("scan tick flagged a value update");

  // a scan tick shows the value held before it
  assert property (@(posedge clk) disable iff (!rst_n)
    take_scan |=> (out_chan.shown_value == $past(disp_value)))
    else $error("scan tick changed the shown value");

endmodule

`default_nettype wire
